// File: hw/rtl/tlpw_pkg.sv
// shared types and constants for the two-level page walker
`default_nettype none

package tlpw_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned OFS_W      = 12;
	localparam int unsigned LARGE_OFS_W = 22;
	localparam int unsigned LARGE_BIT  = 7;
	localparam int unsigned S_DATA_W   = 64;
	localparam int unsigned M_DATA_W   = 72;

	localparam logic CMD_REQUEST  = 1'b0;
	localparam logic CMD_RESPONSE = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [2:0] {
		PHASE_IDLE  = 3'b001,
		PHASE_DIR   = 3'b010,
		PHASE_TABLE = 3'b100
	} phase_t;

	typedef struct packed {
		logic                fault;
		logic [ADDR_W-1:0]   physical_address;
		logic [ADDR_W-1:0]   read_address;
		logic                result_kind;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/two_level_page_walker_unit.sv
// top level of the two-level page walker
`default_nettype none

// Translates 32-bit virtual addresses through a page directory and a page table.
// A request (tuser 0) yields a read request for the directory entry; each memory
// response (tuser 1) yields either the read request for the page table entry or
// the finished translation (fault set, address zero, for an empty entry). A
// response while no walk is running is taken and dropped; a new request abandons
// any running walk. Throughput is one item per clock while s_tready is high: the
// walk state and the result are computed combinationally from the accepted item,
// and the result is registered into a two-entry output buffer. s_tready falls
// only when both buffer entries hold results that m_tready has not taken.
// cfg_ready is always high; write directory_base only while the block is idle.
module two_level_page_walker_unit
	import tlpw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [ADDR_W-1:0]   cfg_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // virtual_address, read_data
	input  wire logic                s_tuser,   // command
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // read_address, physical_address, fault, zero pad
	output logic                     m_tuser    // result_kind
);

	logic [ADDR_W-1:0] base_q;
	phase_t            phase_q;
	phase_t            phase_d;
	logic [ADDR_W-1:0] held_q;
	logic [ADDR_W-1:0] held_d;

	logic [ADDR_W-1:0] vaddr;
	logic [ADDR_W-1:0] rdata;
	logic              accept;
	logic              push;
	logic              pop;
	logic              res_valid;
	result_t           res;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign cfg_ready = 1'b1;
	assign vaddr     = s_tdata[ADDR_W-1:0];
	assign rdata     = s_tdata[2*ADDR_W-1:ADDR_W];
	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign pop       = out_valid_q && m_tready;
	assign push      = accept && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// walk step for the item at the input
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		phase_d   = phase_q;
		held_d    = held_q;
		if (s_tuser == CMD_REQUEST) begin
			res_valid        = 1'b1;
			res.result_kind  = KIND_READ;
			res.read_address = {base_q[ADDR_W-1:OFS_W], {OFS_W{1'b0}}}
				+ {{(ADDR_W-IDX_W-2){1'b0}}, vaddr[ADDR_W-1:ADDR_W-IDX_W], 2'b00};
			phase_d          = PHASE_DIR;
			held_d           = vaddr;
		end else begin
			unique case (phase_q)
				PHASE_DIR: begin
					res_valid = 1'b1;
					if (rdata[LARGE_BIT]) begin
						res.result_kind      = KIND_DONE;
						res.physical_address = {rdata[ADDR_W-1:LARGE_OFS_W],
							held_q[LARGE_OFS_W-1:0]};
						phase_d              = PHASE_IDLE;
					end else if (rdata[ADDR_W-1:OFS_W] == '0) begin
						res.result_kind = KIND_DONE;
						res.fault       = 1'b1;
						phase_d         = PHASE_IDLE;
					end else begin
						// frame plus index*4 never carries past the frame bits
						res.result_kind  = KIND_READ;
						res.read_address = {rdata[ADDR_W-1:OFS_W],
							held_q[LARGE_OFS_W-1:OFS_W], 2'b00};
						phase_d          = PHASE_TABLE;
					end
				end
				PHASE_TABLE: begin
					res_valid       = 1'b1;
					res.result_kind = KIND_DONE;
					phase_d         = PHASE_IDLE;
					if (rdata == '0) begin
						res.fault = 1'b1;
					end else begin
						res.physical_address = {rdata[ADDR_W-1:OFS_W], held_q[OFS_W-1:0]};
					end
				end
				default: begin
					phase_d = PHASE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	// two-entry output buffer: the skid entry takes a result while the head waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.result_kind;
	assign m_tdata  = {{(M_DATA_W-2*ADDR_W-1){1'b0}}, out_q.fault,
		out_q.physical_address, out_q.read_address};

`ifndef SYNTHESIS
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the head is empty");

	a_fault_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fault) |-> (out_q.result_kind == KIND_DONE
			&& out_q.physical_address == '0))
		else $error("fault result is not a finished zero translation");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_READ) |->
			(out_q.physical_address == '0 && !out_q.fault))
		else $error("read request carries translation fields");

	a_table_after_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PHASE_TABLE && !$past(phase_q == PHASE_TABLE)) |->
			$past(phase_q == PHASE_DIR && accept))
		else $error("table phase entered without a directory response");

	a_done_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.result_kind == KIND_DONE) |=> (phase_q == PHASE_IDLE))
		else $error("walk still running after a finished translation");
`endif

endmodule

`default_nettype wire
